// ===== rtl/cfse_pkg.sv =====
// Shared types and constants for the CAN frame signal extractor.
package cfse_pkg;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam int MAX_FRAME_BYTES = 8;
	localparam int DEF_WIDTH       = 47;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FLUSH
	} walk_state_t;

	// One signal definition as held in the table memory.
	typedef struct packed {
		logic [28:0] id;
		logic [3:0]  src;
		logic        be;
		logic [5:0]  fbit;
		logic [6:0]  blen;
	} sig_def_t;

	// Frame under decode.
	typedef struct packed {
		logic [28:0] id;
		logic [3:0]  src;
		logic [3:0]  len;
		logic [63:0] data;
	} frame_t;

	// Match and value for one definition against the current frame.
	typedef struct packed {
		logic        hit;
		logic [63:0] value;
	} ext_res_t;

endpackage

// ===== rtl/cfse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/cfse_extract.sv =====
// Match check and Intel/Motorola bit-field extraction for one definition.
module cfse_extract
	import cfse_pkg::*;
(
	input  sig_def_t def,
	input  frame_t   frame,
	output ext_res_t res
);

	logic [2:0]  start_byte;
	logic [63:0] rev_data;
	logic [63:0] word;
	logic [5:0]  shamt;
	logic [6:0]  span;
	logic [6:0]  nbits;
	logic [63:0] mask;

	// Byte-reverse the payload so a Motorola field reads upward like an Intel one.
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			rev_data[8*b +: 8] = frame.data[8*(7-b) +: 8];
		end
	end

	always_comb begin
		start_byte = def.fbit[5:3];
		if (def.be) begin
			word  = rev_data;
			shamt = {~start_byte, def.fbit[2:0]};
			span  = 7'd64 - 7'(shamt);
		end else begin
			word  = frame.data;
			shamt = def.fbit;
			span  = {frame.len[3:0], 3'b000} - 7'(def.fbit);
		end
		nbits = (def.blen < span) ? def.blen : span;
		// shift of 64 leaves zero, so a full-width field gets an all-ones mask
		mask  = ~({64{1'b1}} << nbits);

		res.value = (word >> shamt) & mask;
		res.hit   = (def.id == frame.id)
			&& ((def.src == 4'd0) || (def.src == frame.src))
			&& ({1'b0, start_byte} < frame.len);
	end

endmodule

// ===== rtl/can_frame_signal_extractor.sv =====
// Top level: CAN signal table, slot walk and result emission.
// Load word: busy stays low, the next word may follow at once.
// Decode word: busy through the walk, drain and flush states, so no new word is taken
//   meanwhile; the walk reads one table slot per cycle from the RAM port.
// Results: each hit is held until the next hit or the flush, then strobed from a register.
// Results are one-cycle strobes on valid; the receiver cannot stall them.
// Reset (arst_n low) clears all valid bits and the walk; table contents stay undefined.
module can_frame_signal_extractor
	import cfse_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [4:0]  slot_index,
	input  logic        entry_enable,
	input  logic [28:0] can_id,
	input  logic [3:0]  bus_source,
	input  logic        big_endian,
	input  logic [5:0]  first_bit,
	input  logic [6:0]  bit_length,
	input  logic [3:0]  frame_len,
	input  logic [63:0] frame_data,
	output logic        valid,
	output logic [4:0]  signal_slot,
	output logic [63:0] raw_value,
	output logic        last_of_frame
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	walk_state_t state_q, state_d;

	logic          accept;
	logic          load_go;
	logic          slot_in_range;
	logic [AW-1:0] wr_addr;
	sig_def_t      wr_def;

	logic          rd_en;
	logic          flush;
	logic [AW-1:0] ctr_q;
	logic          ctr_last;

	logic          slot_vld_q [TABLE_DEPTH];

	frame_t        frame_q;

	logic          rd_s1;
	logic          ok_s1;
	logic [AW-1:0] slot_s1;
	logic [DEF_WIDTH-1:0] rd_word;
	sig_def_t      def_s1;
	ext_res_t      ext_s1;
	logic          hit_s1;

	logic          pend_vld_q;
	logic [AW-1:0] pend_slot_q;
	logic [63:0]   pend_val_q;
	logic          emit;

	logic          valid_q;
	logic [4:0]    slot_q;
	logic [63:0]   value_q;
	logic          last_q;

	// ---------------------------------------------------------------
	// Input word handshake
	// ---------------------------------------------------------------
	assign accept        = start && !busy;
	assign load_go       = accept && (opcode == OP_LOAD);
	assign slot_in_range = 32'(slot_index) < TABLE_DEPTH;
	assign wr_addr       = AW'(slot_index);

	always_comb begin
		wr_def.id   = can_id;
		wr_def.src  = bus_source;
		wr_def.be   = big_endian;
		wr_def.fbit = first_bit;
		wr_def.blen = bit_length;
	end

	// ---------------------------------------------------------------
	// Walk sequencer: issue one slot read per cycle, drain, flush
	// ---------------------------------------------------------------
	assign ctr_last = (ctr_q == AW'(TABLE_DEPTH - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == OP_DECODE)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (ctr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		flush = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy  = 1'b0;
			ST_WALK:  rd_en = 1'b1;
			ST_DRAIN: ;
			ST_FLUSH: flush = 1'b1;
			default:  busy  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctr_q   <= '0;
		end else begin
			state_q <= state_d;
			// restart the slot counter on every accepted word
			if (accept) begin
				ctr_q <= '0;
			end else if (rd_en && !ctr_last) begin
				ctr_q <= ctr_q + AW'(1);
			end
		end
	end

	// Capture the frame; saturate the length to the payload size.
	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_DECODE)) begin
			frame_q.id   <= can_id;
			frame_q.src  <= bus_source;
			frame_q.len  <= (frame_len > 4'(MAX_FRAME_BYTES)) ? 4'(MAX_FRAME_BYTES)
				: frame_len;
			frame_q.data <= frame_data;
		end
	end

	// ---------------------------------------------------------------
	// Slot valid bits (flops) and definition memory
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slot_vld_q[i] <= 1'b0;
			end
		end else if (load_go && slot_in_range) begin
			slot_vld_q[wr_addr] <= entry_enable;
		end
	end

	// Loads never overlap the walk (busy holds them off), so no forwarding is needed.
	cfse_ram #(
		.WIDTH(DEF_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (load_go && slot_in_range && entry_enable),
		.waddr(wr_addr),
		.wdata(wr_def),
		.re   (rd_en),
		.raddr(ctr_q),
		.rdata(rd_word)
	);

	// Stage 1 tags are registered alongside the RAM read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ok_s1   <= slot_vld_q[ctr_q];
			slot_s1 <= ctr_q;
		end
	end

	assign def_s1 = rd_word;

	cfse_extract u_extract (
		.def  (def_s1),
		.frame(frame_q),
		.res  (ext_s1)
	);

	assign hit_s1 = rd_s1 && ok_s1 && ext_s1.hit;

	// ---------------------------------------------------------------
	// Result emission: hold each hit until the next hit or the flush,
	// so the final one can carry last_of_frame.
	// ---------------------------------------------------------------
	assign emit = pend_vld_q && (hit_s1 || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (hit_s1) begin
				pend_vld_q <= 1'b1;
			end else if (flush) begin
				pend_vld_q <= 1'b0;
			end
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1) begin
			pend_slot_q <= slot_s1;
			pend_val_q  <= ext_s1.value;
		end
		if (emit) begin
			slot_q  <= 5'(pend_slot_q);
			value_q <= pend_val_q;
			last_q  <= flush;
		end
	end

	assign valid         = valid_q;
	assign signal_slot   = slot_q;
	assign raw_value     = value_q;
	assign last_of_frame = last_q;

`ifndef SYNTHESIS
	a_flush_emits_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && pend_vld_q) |=> (valid && last_of_frame))
		else $error("pending hit not emitted as last at flush");

	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last_of_frame) |=> !valid)
		else $error("result strobe right after last of frame");

	a_result_needs_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result emitted outside a frame walk");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_LOAD) |=> !busy)
		else $error("load word started a walk");

	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (state_q == ST_WALK || state_q == ST_DRAIN))
		else $error("read data arrived outside walk or drain");
`endif

endmodule
